// ----- src/nearest_neighbor_tour_assert.svh -----
// ----------------------------------------------------------------------------
// nearest_neighbor_tour assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_TOUR_ASSERT_SVH
`define NEAREST_NEIGHBOR_TOUR_ASSERT_SVH

// same-cycle implication
`define NNT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NNT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/nnt_pkg.sv -----
// ----------------------------------------------------------------------------
// nnt_pkg
// Types, constants and helpers shared by the nearest-neighbor tour block.
// ----------------------------------------------------------------------------
package nnt_pkg;

  localparam int CITY_W  = 6;
  localparam int POS_W   = 6;
  localparam int DIST_W  = 30;
  localparam int COST_W  = 36;
  localparam int COUNT_W = 7;
  localparam int SLOT_W  = 11;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CITY_W-1:0] city_a;
    logic [CITY_W-1:0] city_b;
    logic [DIST_W-1:0] distance;
    logic [CITY_W-1:0] start_city;
  } in_item_t;

  typedef struct packed {
    logic [CITY_W-1:0] city;
    logic [POS_W-1:0]  position;
    logic              last;
    logic [COST_W-1:0] tour_cost;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_CLOSE_RD,
    ST_CLOSE_ADD
  } state_t;

  typedef struct packed {
    logic load;
    logic run_start;
    logic emit;
    logic scan_rd;
    logic update;
    logic close_rd;
    logic close_add;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic scan_last;
    logic pos_last;
    logic out_free;
  } dp_status_t;

  // triangular slot of an unordered pair of distinct cities
  function automatic logic [SLOT_W-1:0] pair_slot(input logic [CITY_W-1:0] a,
                                                  input logic [CITY_W-1:0] b);
    logic [CITY_W-1:0]   hi;
    logic [CITY_W-1:0]   lo;
    logic [2*CITY_W-1:0] prod;
    hi   = (a > b) ? a : b;
    lo   = (a > b) ? b : a;
    prod = (2*CITY_W)'(hi) * (2*CITY_W)'(hi - 1'b1);
    return SLOT_W'(prod >> 1) + SLOT_W'(lo);
  endfunction

endpackage

// ----- src/nnt_ram.sv -----
// ----------------------------------------------------------------------------
// nnt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nnt_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2016,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/nnt_ctrl.sv -----
// ----------------------------------------------------------------------------
// nnt_ctrl
// Sequencer for loads, tour scans, closing edge and result hand-off.
// ----------------------------------------------------------------------------
module nnt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  nnt_pkg::op_t       in_op,
  output logic               in_stall,
  input  nnt_pkg::dp_status_t status,
  output nnt_pkg::ctrl_cmd_t  cmd,
  output nnt_pkg::state_t     state
);

  import nnt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            cmd.load = 1'b1;
          end else if (status.start_ok) begin
            cmd.run_start = 1'b1;
            state_nxt     = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = status.pos_last ? ST_IDLE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = status.pos_last ? ST_CLOSE_RD : ST_EMIT;
      end
      ST_CLOSE_RD: begin
        cmd.close_rd = 1'b1;
        state_nxt    = ST_CLOSE_ADD;
      end
      ST_CLOSE_ADD: begin
        cmd.close_add = 1'b1;
        state_nxt     = ST_EMIT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

// ----- src/nnt_dp.sv -----
// ----------------------------------------------------------------------------
// nnt_dp
// Distance store, visited set, nearest-city search and result register.
// ----------------------------------------------------------------------------
module nnt_dp #(
  parameter int MAX_CITIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nnt_pkg::COUNT_W-1:0]     cfg_data,
  input  nnt_pkg::in_item_t               in_data,
  input  nnt_pkg::ctrl_cmd_t              cmd,
  output nnt_pkg::dp_status_t             status,
  output logic                            out_valid,
  input  logic                            out_stall,
  output nnt_pkg::out_item_t              out_data
);

  import nnt_pkg::*;

  localparam int DEPTH = MAX_CITIES * (MAX_CITIES - 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_CITIES);

  logic [COUNT_W-1:0]    city_count_r;
  logic [MAX_CITIES-1:0] visited_r, visited_nxt;
  logic [CITY_W-1:0]     cur_r, cur_nxt;
  logic [CITY_W-1:0]     first_r, first_nxt;
  logic [COST_W-1:0]     cost_r, cost_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [CITY_W-1:0]     j_r, j_nxt;
  logic                  tag_vld_r, tag_vld_nxt;
  logic [CITY_W-1:0]     tag_j_r;
  logic                  found_r, found_nxt;
  logic [DIST_W-1:0]     bestd_r, bestd_nxt;
  logic [CITY_W-1:0]     best_r, best_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;

  logic [COUNT_W-1:0]    n_eff;
  logic [CITY_W-1:0]     nm1;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_slot;
  logic [SLOT_W-1:0]     rd_slot;
  logic [DIST_W-1:0]     rd_data;

  always_comb begin
    n_eff = city_count_r;
    if (city_count_r < COUNT_MIN) begin
      n_eff = COUNT_MIN;
    end else if (city_count_r > COUNT_MAX) begin
      n_eff = COUNT_MAX;
    end
  end

  assign nm1 = CITY_W'(n_eff - 1'b1);

  assign wr_en = cmd.load && (in_data.city_a != in_data.city_b)
              && ({1'b0, in_data.city_a} < COUNT_MAX)
              && ({1'b0, in_data.city_b} < COUNT_MAX);
  assign wr_slot = pair_slot(in_data.city_a, in_data.city_b);
  assign rd_slot = cmd.close_rd ? pair_slot(cur_r, first_r) : pair_slot(cur_r, j_r);

  nnt_ram #(
    .WIDTH (DIST_W),
    .DEPTH (DEPTH)
  ) u_dist_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_slot[AW-1:0]),
    .wdata (in_data.distance),
    .raddr (rd_slot[AW-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    visited_nxt   = visited_r;
    cur_nxt       = cur_r;
    first_nxt     = first_r;
    cost_nxt      = cost_r;
    pos_nxt       = pos_r;
    j_nxt         = j_r;
    found_nxt     = found_r;
    bestd_nxt     = bestd_r;
    best_nxt      = best_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    tag_vld_nxt   = cmd.scan_rd && !visited_r[j_r[IDX_W-1:0]];

    if (cmd.run_start) begin
      visited_nxt = '0;
      visited_nxt[in_data.start_city[IDX_W-1:0]] = 1'b1;
      cur_nxt   = in_data.start_city;
      first_nxt = in_data.start_city;
      cost_nxt  = '0;
      pos_nxt   = '0;
    end

    if (cmd.emit) begin
      out_valid_nxt      = 1'b1;
      out_nxt.city       = cur_r;
      out_nxt.position   = pos_r;
      out_nxt.last       = (pos_r == nm1);
      out_nxt.tour_cost  = (pos_r == nm1) ? cost_r : '0;
      pos_nxt            = pos_r + 1'b1;
      j_nxt              = '0;
      found_nxt          = 1'b0;
    end

    if (cmd.scan_rd) begin
      j_nxt = j_r + 1'b1;
    end

    if (tag_vld_r && (!found_r || (rd_data < bestd_r))) begin
      found_nxt = 1'b1;
      bestd_nxt = rd_data;
      best_nxt  = tag_j_r;
    end

    if (cmd.update) begin
      cost_nxt = cost_r + COST_W'(bestd_r);
      cur_nxt  = best_r;
      visited_nxt[best_r[IDX_W-1:0]] = 1'b1;
    end

    if (cmd.close_add) begin
      cost_nxt = cost_r + COST_W'(rd_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= COUNT_RESET;
      visited_r    <= '0;
      cur_r        <= '0;
      first_r      <= '0;
      cost_r       <= '0;
      pos_r        <= '0;
      j_r          <= '0;
      tag_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        city_count_r <= cfg_data;
      end
      visited_r    <= visited_nxt;
      cur_r        <= cur_nxt;
      first_r      <= first_nxt;
      cost_r       <= cost_nxt;
      pos_r        <= pos_nxt;
      j_r          <= j_nxt;
      tag_vld_r    <= tag_vld_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_j_r <= j_r;
    bestd_r <= bestd_nxt;
    best_r  <= best_nxt;
    out_r   <= out_nxt;
  end

  assign status.start_ok  = ({1'b0, in_data.start_city} < n_eff);
  assign status.scan_last = (j_r == nm1);
  assign status.pos_last  = (pos_r == nm1);
  assign status.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/nearest_neighbor_tour.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_tour
// Greedy nearest-neighbor tour over a symmetric pair-distance store.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  nnt_pkg::in_item_t
//  out      output     out_valid / out_stall nnt_pkg::out_item_t
//  cfg      input      cfg_we               city_count (7 bits)
//
//  Loads stream at one per cycle while the sequencer is idle (in_stall low).
//  Each step of a run reads n distances through the store's single read port.
//  rst_n is synchronous; the distance store is not cleared by reset.
//  Output stalls hold the result register and pause the sequencer.
// ----------------------------------------------------------------------------
module nearest_neighbor_tour #(
  parameter int MAX_CITIES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [nnt_pkg::COUNT_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  nnt_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output nnt_pkg::out_item_t          out_data
);

  import nnt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  state_t     state;

  nnt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  nnt_dp #(
    .MAX_CITIES (MAX_CITIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`include "nearest_neighbor_tour_assert.svh"

  `NNT_ASSERT_IMP(a_cmd_exclusive, 1'b1, $onehot0({cmd.run_start, cmd.emit, cmd.scan_rd, cmd.update, cmd.close_rd, cmd.close_add}), "sequencer issued overlapping commands")
  `NNT_ASSERT_NXT(a_emit_shows, cmd.emit, out_valid, "emitted result not presented")
  `NNT_ASSERT_IMP(a_cost_on_last, out_valid && !out_data.last, out_data.tour_cost == '0, "tour cost on a non-final result")
  `NNT_ASSERT_IMP(a_busy_stalls, state != ST_IDLE, in_stall, "input taken during a tour")

endmodule
